// ----- src/ps2_mouse_packet_cursor_tracker_assert.svh -----
// Assertion macros for the PS/2 mouse cursor tracker.
// Used by the top level; needs clk and rst_n in the including scope.
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_ASSERT_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PS2MCT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define PS2MCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ps2mct_pkg.sv -----
// Shared types and constants for the PS/2 mouse cursor tracker.
// No dependencies; imported by every module of the block.
package ps2mct_pkg;

  // Configuration register layout
  localparam int SIZE_W     = 13;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd1024;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd768;

  // Register index codes (byte address bit 2)
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [7:0] BUTTON_MASK = 8'h07;

  // Byte position inside a three-byte packet
  typedef enum logic [2:0] {
    PH_BTN = 3'b001,
    PH_X   = 3'b010,
    PH_Y   = 3'b100
  } ps2mct_phase_t;

  // Framer to tracker: a packet completes on the current byte
  typedef struct packed {
    logic       done;
    logic [2:0] buttons;
    logic [7:0] dx;
    logic [7:0] dy;
  } ps2mct_pkt_t;

endpackage

// ----- src/ps2mct_framer.sv -----
// Groups raw mouse bytes into three-byte packets with a phase counter.
// Depends on ps2mct_pkg.
module ps2mct_framer
  import ps2mct_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [7:0]  data_byte,
  output ps2mct_pkt_t pkt
);

  ps2mct_phase_t phase_r, phase_nxt;
  logic [7:0]    first_r, first_nxt;
  logic [7:0]    second_r, second_nxt;

  // Phase step; the byte is stored by its position
  always_comb begin
    phase_nxt  = phase_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    if (fire) begin
      case (phase_r)
        PH_X: begin
          second_nxt = data_byte;
          phase_nxt  = PH_Y;
        end
        PH_Y: begin
          phase_nxt = PH_BTN;
        end
        default: begin
          first_nxt = data_byte;
          phase_nxt = PH_X;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_BTN;
      first_r  <= '0;
      second_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

  // Current byte closes the packet when it is the Y byte
  assign pkt.done    = (phase_r == PH_Y);
  assign pkt.buttons = 3'(first_r & BUTTON_MASK);
  assign pkt.dx      = second_r;
  assign pkt.dy      = data_byte;

endmodule

// ----- src/ps2mct_clamp.sv -----
// One cursor axis: adds a signed delta and clamps to [0, size-1] (size 0 as 1, capped at 2^COORD_BITS).
// Depends on ps2mct_pkg for the size register width.
module ps2mct_clamp
  import ps2mct_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0] pos,
  input  logic signed [8:0]     delta,
  input  logic [SIZE_W-1:0]     size,
  output logic [COORD_BITS-1:0] new_pos
);

  localparam int SUM_W = COORD_BITS + 2;
  localparam int LIM_W = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 1;

  logic signed [SUM_W-1:0] sum;
  logic [LIM_W-1:0]        size_ext;
  logic [LIM_W-1:0]        span;
  logic [LIM_W-1:0]        eff;
  logic [COORD_BITS-1:0]   max_pos;

  // Effective size: zero acts as one, oversize acts as full span
  always_comb begin
    size_ext = LIM_W'(size);
    span     = LIM_W'(1) << COORD_BITS;
    if (size_ext == '0) begin
      eff = LIM_W'(1);
    end else if (size_ext > span) begin
      eff = span;
    end else begin
      eff = size_ext;
    end
    max_pos = COORD_BITS'(eff - LIM_W'(1));
  end

  // Signed add then clamp
  always_comb begin
    sum = $signed({2'b00, pos}) + $signed({{(SUM_W-9){delta[8]}}, delta});
    if (sum[SUM_W-1]) begin
      new_pos = '0;
    end else if ($unsigned(sum) > SUM_W'(max_pos)) begin
      new_pos = max_pos;
    end else begin
      new_pos = COORD_BITS'($unsigned(sum));
    end
  end

endmodule

// ----- src/ps2mct_tracker.sv -----
// Cursor position registers updated by each completed packet.
// Depends on ps2mct_pkg and ps2mct_clamp.
module ps2mct_tracker
  import ps2mct_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  ps2mct_pkt_t           pkt,
  input  logic [SIZE_W-1:0]     screen_width,
  input  logic [SIZE_W-1:0]     screen_height,
  output logic [COORD_BITS-1:0] next_x,
  output logic [COORD_BITS-1:0] next_y
);

  logic [COORD_BITS-1:0] pos_x_r;
  logic [COORD_BITS-1:0] pos_y_r;
  logic signed [8:0]     dx_ext;
  logic signed [8:0]     dy_neg;

  // X as received; Y negated in 9 bits so -128 becomes +128
  assign dx_ext = $signed({pkt.dx[7], pkt.dx});
  assign dy_neg = -$signed({pkt.dy[7], pkt.dy});

  ps2mct_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_x (
    .pos     (pos_x_r),
    .delta   (dx_ext),
    .size    (screen_width),
    .new_pos (next_x)
  );

  ps2mct_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_y (
    .pos     (pos_y_r),
    .delta   (dy_neg),
    .size    (screen_height),
    .new_pos (next_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
    end else if (load) begin
      pos_x_r <= next_x;
      pos_y_r <= next_y;
    end
  end

endmodule

// ----- src/ps2_mouse_packet_cursor_tracker.sv -----
// Channel | Dir | Contents
// in_     | in  | tdata[7:0] data_byte
// out_    | out | tdata: cursor_x, cursor_y, buttons, zero pad
// cfg_    | in  | APB, 0x0 screen_width, 0x4 screen_height
//
// One byte is taken per cycle while in_tready is high; each byte passes
// through the input register, and the third byte of a packet then loads the
// result register, which drives out_tvalid.
// Reset: phase returns to the button byte, stored bytes and cursor clear to zero; sizes go to 1024x768.
// in_tready drops only while a packet-closing byte waits on a full result
// register that is not being taken.
//
// Top level of the PS/2 mouse cursor tracker.
// Depends on ps2mct_pkg, ps2mct_framer, ps2mct_tracker and the assert header.
`include "ps2_mouse_packet_cursor_tracker_assert.svh"

module ps2_mouse_packet_cursor_tracker
  import ps2mct_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input stream
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [7:0] data_byte
  // result stream
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // cursor_x, cursor_y (COORD_BITS each), buttons (3), zeros to a byte
  output logic [((2*COORD_BITS+3+7)/8)*8-1:0] out_tdata,
  // configuration
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [CFG_DATA_W-1:0]     cfg_prdata,
  output logic                      cfg_pready
);

  localparam int OUT_W = ((2*COORD_BITS+3+7)/8)*8;
  localparam int PAD_W = OUT_W - (2*COORD_BITS+3);

  logic [SIZE_W-1:0]     width_r;
  logic [SIZE_W-1:0]     height_r;
  logic                  cfg_wr;

  logic                  s1_valid_r;
  logic [7:0]            s1_byte_r;
  logic                  s1_go;
  logic                  in_fire;
  logic                  out_load;

  ps2mct_pkt_t           pkt;
  logic [COORD_BITS-1:0] next_x;
  logic [COORD_BITS-1:0] next_y;

  logic                  out_valid_r;
  logic [COORD_BITS-1:0] out_x_r;
  logic [COORD_BITS-1:0] out_y_r;
  logic [2:0]            out_btn_r;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_SCREEN_WIDTH:  width_r  <= cfg_pwdata[SIZE_W-1:0];
        REG_SCREEN_HEIGHT: height_r <= cfg_pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_SCREEN_WIDTH:  cfg_prdata = CFG_DATA_W'(width_r);
      REG_SCREEN_HEIGHT: cfg_prdata = CFG_DATA_W'(height_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // Input register; a held word advances unless it closes a packet into a
  // full, stalled result register
  assign s1_go     = s1_valid_r && (!pkt.done || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = s1_go && pkt.done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
    end
  end

  ps2mct_framer u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_go),
    .data_byte (s1_byte_r),
    .pkt       (pkt)
  );

  ps2mct_tracker #(.COORD_BITS(COORD_BITS)) u_tracker (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (out_load),
    .pkt           (pkt),
    .screen_width  (width_r),
    .screen_height (height_r),
    .next_x        (next_x),
    .next_y        (next_y)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r   <= next_x;
      out_y_r   <= next_y;
      out_btn_r <= pkt.buttons;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_btn_r, out_y_r, out_x_r};

  // Checks
  `PS2MCT_ASSERT_NOW(a_stall_cause, !in_tready, s1_valid_r && out_valid_r && !out_tready, "input stalled without a blocked result")
  `PS2MCT_ASSERT_NEXT(a_result_loaded, out_load, out_valid_r, "closed packet did not produce a result")
  `PS2MCT_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s1_go, s1_valid_r && $stable(s1_byte_r), "held input word lost or changed")

endmodule

// ----- sim/ps2mct_cursor_checker.sv -----
// Checker for the PS/2 mouse cursor tracker: follows the config, input and
// result channels, tracks the cursor on its own and compares every result word.
// Depends on ps2mct_pkg.
module ps2mct_cursor_checker
  import ps2mct_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int OUT_W      = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_W-1:0]      out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                  cfg_pready,
  output int                    fail_count,
  output int                    pending_reports
);

  typedef struct packed {
    logic [2:0]            buttons;
    logic [COORD_BITS-1:0] cursor_y;
    logic [COORD_BITS-1:0] cursor_x;
  } cursor_report_t;

  // Own copy of the screen size and packet state
  logic [SIZE_W-1:0]     width_q;
  logic [SIZE_W-1:0]     height_q;
  ps2mct_phase_t         phase_q;
  logic [7:0]            btn_byte_q;
  logic [7:0]            x_byte_q;
  logic [COORD_BITS-1:0] pos_x_q;
  logic [COORD_BITS-1:0] pos_y_q;

  cursor_report_t reports_due[$];

  // Size 0 acts as 1, sizes past the coordinate range saturate to it
  function automatic logic [COORD_BITS-1:0] clamp_to_screen(input int v,
                                                            input logic [SIZE_W-1:0] size);
    int span;
    if (size == '0)
      span = 1;
    else if (int'(size) > (1 << COORD_BITS))
      span = 1 << COORD_BITS;
    else
      span = int'(size);
    if (v < 0)
      return '0;
    if (v >= span)
      return COORD_BITS'(span - 1);
    return COORD_BITS'(v);
  endfunction

  // Advance the packet framer by one byte; the Y byte closes a packet
  task automatic track_byte(input logic [7:0] b);
    int             nx;
    int             ny;
    cursor_report_t rpt;
    case (phase_q)
      PH_X: begin
        x_byte_q = b;
        phase_q  = PH_Y;
      end
      PH_Y: begin
        // Y axis is inverted; a Y byte of -128 moves the cursor up by +128
        nx = int'(pos_x_q) + int'($signed(x_byte_q));
        ny = int'(pos_y_q) - int'($signed(b));
        pos_x_q = clamp_to_screen(nx, width_q);
        pos_y_q = clamp_to_screen(ny, height_q);
        rpt.cursor_x = pos_x_q;
        rpt.cursor_y = pos_y_q;
        rpt.buttons  = 3'(btn_byte_q & BUTTON_MASK);
        reports_due.push_back(rpt);
        phase_q = PH_BTN;
      end
      default: begin
        btn_byte_q = b;
        phase_q    = PH_X;
      end
    endcase
  endtask

  always @(posedge clk) begin
    cursor_report_t got;
    cursor_report_t want;
    if (!rst_n) begin
      fail_count = 0;
      width_q    = WIDTH_RST;
      height_q   = HEIGHT_RST;
      phase_q    = PH_BTN;
      btn_byte_q = '0;
      x_byte_q   = '0;
      pos_x_q    = '0;
      pos_y_q    = '0;
      reports_due.delete();
    end else begin
      // Register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_SCREEN_WIDTH)
          width_q = cfg_pwdata[SIZE_W-1:0];
        else
          height_q = cfg_pwdata[SIZE_W-1:0];
      end

      // Result words against the oldest expectation
      if (out_tvalid && out_tready) begin
        got.cursor_x = out_tdata[COORD_BITS-1:0];
        got.cursor_y = out_tdata[2*COORD_BITS-1:COORD_BITS];
        got.buttons  = out_tdata[2*COORD_BITS+2 -: 3];
        if (reports_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result word: x=%0d y=%0d buttons=%0d",
                     got.cursor_x, got.cursor_y, got.buttons);
        end else begin
          want = reports_due.pop_front();
          if (got.cursor_x !== want.cursor_x || got.cursor_y !== want.cursor_y ||
              got.buttons !== want.buttons) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"result mismatch: x exp %0d got %0d, y exp %0d got %0d,",
                        " buttons exp %0d got %0d"},
                       want.cursor_x, got.cursor_x, want.cursor_y, got.cursor_y,
                       want.buttons, got.buttons);
          end
        end
      end

      // Mouse bytes
      if (in_tvalid && in_tready)
        track_byte(in_tdata);
    end
    pending_reports = reports_due.size();
  end

endmodule

// ----- sim/ps2_mouse_packet_cursor_tracker_test.sv -----
// Testbench top for the PS/2 mouse cursor tracker: drives mouse bytes, screen
// sizes and result back-pressure, and reports the verdict.
// Depends on ps2mct_pkg, the tracker RTL and ps2mct_cursor_checker.
module ps2_mouse_packet_cursor_tracker_test;
  import ps2mct_pkg::*;

  localparam int COORD_BITS = 12;
  localparam int OUT_W      = ((2*COORD_BITS+3+7)/8)*8;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int fail_count;
  int pending_reports;

  // Idle rates in percent, and long result stalls requested by the stimulus
  int tx_idle_pct  = 28;
  int rx_idle_pct  = 78;
  int hold_reqs    = 0;
  int holds_served = 0;
  int stall_left   = 0;

  logic [7:0] opening_bytes[$];

  always #5 clk = ~clk;

  ps2_mouse_packet_cursor_tracker #(
    .COORD_BITS(COORD_BITS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  ps2mct_cursor_checker #(
    .COORD_BITS(COORD_BITS),
    .OUT_W     (OUT_W)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_pready     (cfg_pready),
    .fail_count     (fail_count),
    .pending_reports(pending_reports)
  );

  // Result side: random stalls, plus a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_reqs != holds_served) begin
      holds_served = hold_reqs;
      stall_left   = 300;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Offer one byte, with random gaps before it; returns on a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Delta byte leaning one way so the cursor reaches the screen edges
  function automatic logic [7:0] pick_delta(input int drift);
    if (drift == 0 || $urandom_range(0, 9) == 0)
      return 8'($urandom_range(0, 255));
    if (drift > 0)
      return 8'($urandom_range(0, 127));
    return 8'($urandom_range(128, 255));
  endfunction

  // Y bytes are negated by the block, so the Y lean is flipped here
  task automatic send_packet(input int drift_x, input int drift_y);
    send_byte(8'($urandom_range(0, 255)));
    send_byte(pick_delta(drift_x));
    send_byte(pick_delta(-drift_y));
  endtask

  // APB write; upper data bits carry noise that the register must drop
  task automatic write_size(input logic idx, input logic [SIZE_W-1:0] value);
    logic [31:0] noise;
    noise = $urandom;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {noise[CFG_DATA_W-1:SIZE_W], value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Stop offering and let all results drain, then cover the pipeline depth
  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_reports != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                           input int tx, input int rx, input int packets,
                           input int drift_x, input int drift_y, input bit squeeze);
    drain();
    write_size(REG_SCREEN_WIDTH, w);
    write_size(REG_SCREEN_HEIGHT, h);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    if (squeeze)
      hold_reqs++;
    repeat (packets) send_packet(drift_x, drift_y);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed packets at the reset size: delta extremes, Y of -128,
    // all button codes, sync bit set and clear, clamping at zero
    opening_bytes = '{8'h00, 8'h00, 8'h00,
                      8'h01, 8'h80, 8'h80,
                      8'h02, 8'h7f, 8'h7f,
                      8'h04, 8'hff, 8'hff,
                      8'hff, 8'h7f, 8'h81,
                      8'h08, 8'h01, 8'h01,
                      8'h03, 8'h80, 8'h7f,
                      8'h05, 8'h7f, 8'h80,
                      8'h06, 8'h00, 8'h80};
    foreach (opening_bytes[i])
      send_byte(opening_bytes[i]);

    // Zero size, then oversized with a long result stall, then small, full-span, 1x1 and random sizes
    run_phase(13'd0, 13'd0, 28, 78, 10, 0, 0, 1'b0);
    run_phase(13'd8191, 13'd5000, 28, 78, 80, 1, 1, 1'b1);
    run_phase(13'd100, 13'd50, 78, 28, 40, -1, 1, 1'b0);
    run_phase(13'd4096, 13'd4096, 78, 28, 80, 1, -1, 1'b0);
    run_phase(13'd1, 13'd1, 0, 0, 10, 0, 0, 1'b0);
    run_phase(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
              0, 0, 60, 0, 0, 1'b0);
    run_phase(13'($urandom_range(0, 8191)), 13'd2000, 0, 0, 40, -1, 1, 1'b0);

    drain();
    repeat (4) @(negedge clk);
    if (fail_count == 0 && pending_reports == 0)
      $display("ps2_mouse_packet_cursor_tracker regression: pass");
    else
      $display("ps2_mouse_packet_cursor_tracker regression: fail");
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("ps2_mouse_packet_cursor_tracker regression: fail");
    $finish;
  end

endmodule
